// ----- design/jhbd_pkg.sv -----
// ----------------------------------------------------------------------------
// jhbd_pkg
// Shared types and constants of the canonical Huffman bit decoder: command
// and status codes, field widths, and the control bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package jhbd_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned LC_W     = 5;
  localparam int unsigned VC_W     = 9;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned OFFSET_W = 9;
  localparam int unsigned IDX_W    = OFFSET_W + 1;

  // slave tdata: position, data, length_count, value_count, bit_req
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned M_TDATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_LEN = 2'd0,
    CMD_LOAD_SYM = 2'd1,
    CMD_BUILD    = 2'd2,
    CMD_DECODE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING   = 3'd0,
    ST_SYMBOL    = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_INVALID   = 3'd3,
    ST_BUILD_OK  = 3'd4,
    ST_TOO_FEW   = 3'd5,
    ST_LEFT_OVER = 3'd6
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_len;
    logic    load_sym;
    logic    build_clear;
    logic    build_start;
    logic    build_step;
    logic    build_finish;
    logic    dec_step;
    logic    out_load;
    logic    out_from_ram;
    status_e out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic len_zero;
    logic table_empty;
    logic stuck;
    logic hit;
    logic build_last;
    logic too_many;
    logic too_few;
  } stat_t;

endpackage

// ----- design/jhbd_ram.sv -----
// ----------------------------------------------------------------------------
// jhbd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module jhbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/jhbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// jhbd_ctrl
// Sequencer of the decoder: takes requests, steps the table build one length
// per cycle, waits on the symbol memory, and owns the result valid flag.
// ----------------------------------------------------------------------------
module jhbd_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_valid_i,
  output logic                     s_ready_o,
  input  logic [jhbd_pkg::CMD_W-1:0] command_i,
  output logic                     m_valid_o,
  input  logic                     m_ready_i,
  output jhbd_pkg::cmd_t           cmd_o,
  input  jhbd_pkg::stat_t          stat_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUILD,
    S_FINISH,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  jhbd_pkg::cmd_t cmd;

  assign s_ready_o = (state_q == S_IDLE) && (!out_valid_q || m_ready_i);
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = out_valid_q;
  assign cmd_o     = cmd;

  always_comb begin
    cmd        = '0;
    cmd.out_status = jhbd_pkg::ST_PENDING;
    state_d    = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (jhbd_pkg::cmd_e'(command_i))
            jhbd_pkg::CMD_LOAD_LEN: begin
              cmd.load_len = 1'b1;
              cmd.out_load = 1'b1;
            end
            jhbd_pkg::CMD_LOAD_SYM: begin
              cmd.load_sym = 1'b1;
              cmd.out_load = 1'b1;
            end
            jhbd_pkg::CMD_BUILD: begin
              cmd.build_clear = 1'b1;
              if (stat_i.len_zero) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = jhbd_pkg::ST_BUILD_OK;
              end else begin
                cmd.build_start = 1'b1;
                state_d         = S_BUILD;
              end
            end
            jhbd_pkg::CMD_DECODE: begin
              if (stat_i.table_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = jhbd_pkg::ST_EMPTY;
              end else if (stat_i.stuck) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = jhbd_pkg::ST_INVALID;
              end else begin
                cmd.dec_step = 1'b1;
                if (stat_i.hit) begin
                  state_d = S_READ;
                end else begin
                  cmd.out_load = 1'b1;
                end
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_BUILD: begin
        cmd.build_step = 1'b1;
        if (stat_i.build_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.build_finish = 1'b1;
        cmd.out_load     = 1'b1;
        if (stat_i.too_many) begin
          cmd.out_status = jhbd_pkg::ST_TOO_FEW;
        end else if (stat_i.too_few) begin
          cmd.out_status = jhbd_pkg::ST_LEFT_OVER;
        end else begin
          cmd.out_status = jhbd_pkg::ST_BUILD_OK;
        end
        state_d = S_IDLE;
      end
      S_READ: begin
        cmd.out_load     = 1'b1;
        cmd.out_from_ram = 1'b1;
        cmd.out_status   = jhbd_pkg::ST_SYMBOL;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // the result register is only loaded when it is empty or drains this cycle
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/jhbd_dpath.sv -----
// ----------------------------------------------------------------------------
// jhbd_dpath
// Datapath of the decoder: per-length count store, canonical code assigner,
// first-code / offset tables, bit walker, symbol memory and result register.
// ----------------------------------------------------------------------------
module jhbd_dpath #(
  parameter int unsigned MAX_CODE_LENGTH = 16,
  parameter int unsigned MAX_SYMBOLS     = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [jhbd_pkg::POS_W-1:0]    position_i,
  input  logic [jhbd_pkg::DATA_W-1:0]   data_i,
  input  logic [jhbd_pkg::LC_W-1:0]     length_count_i,
  input  logic [jhbd_pkg::VC_W-1:0]     value_count_i,
  input  logic                          bit_req_i,
  input  jhbd_pkg::cmd_t                cmd_i,
  output jhbd_pkg::stat_t               stat_o,
  output logic [jhbd_pkg::STATUS_W-1:0] status_o,
  output logic [jhbd_pkg::SYM_W-1:0]    symbol_o
);

  localparam int unsigned L     = MAX_CODE_LENGTH;
  localparam int unsigned LW    = $clog2(L + 1);
  localparam int unsigned DIW   = (L > 1) ? $clog2(L) : 1;
  localparam int unsigned CODEW = L + 1;
  localparam int unsigned CW    = (CODEW > jhbd_pkg::CNT_W) ? CODEW : jhbd_pkg::CNT_W;
  localparam int unsigned TOTW  = $clog2(L * 255 + 1);
  localparam int unsigned CMPW  = (TOTW > jhbd_pkg::VC_W) ? TOTW : jhbd_pkg::VC_W;
  localparam int unsigned AW    = $clog2(MAX_SYMBOLS);

  // tables
  logic [jhbd_pkg::CNT_W-1:0]    cnt_q    [L];
  logic [L-1:0]                  first_q  [L];
  logic [jhbd_pkg::CNT_W-1:0]    placed_q [L];
  logic [jhbd_pkg::OFFSET_W-1:0] offset_q [L];

  // walk state
  logic [LW-1:0] lengths_q;
  logic [L-1:0]  partial_q;
  logic [LW-1:0] depth_q;
  logic          stuck_q;
  logic          sym_ok_q;

  // build state
  logic [DIW-1:0]              b_idx_q;
  logic [LW-1:0]               b_len_q;
  logic [CODEW-1:0]            b_code_q;
  logic [CODEW-1:0]            b_free_q;
  logic [TOTW-1:0]             b_total_q;
  logic [jhbd_pkg::VC_W-1:0]   b_vc_q;

  logic [jhbd_pkg::STATUS_W-1:0] out_status_q;
  logic [jhbd_pkg::SYM_W-1:0]    out_symbol_q;

  // ---- build step ----
  logic [LW-1:0]              len_sat;
  logic [CODEW-1:0]           code_sh, free_sh;
  logic [CW-1:0]              cnt_w, free_w, put_w;
  logic [jhbd_pkg::CNT_W-1:0] put;
  logic [jhbd_pkg::VC_W-1:0]  vc_cap;

  assign len_sat = ({1'b0, length_count_i} > (jhbd_pkg::LC_W + 1)'(L)) ? LW'(L)
                                                                      : LW'(length_count_i);
  assign code_sh = {b_code_q[L-1:0], 1'b0};
  assign free_sh = {b_free_q[L-1:0], 1'b0};
  assign cnt_w   = CW'(cnt_q[b_idx_q]);
  assign free_w  = CW'(free_sh);
  assign put_w   = (cnt_w < free_w) ? cnt_w : free_w;
  assign put     = put_w[jhbd_pkg::CNT_W-1:0];
  assign vc_cap  = (b_vc_q > jhbd_pkg::VC_W'(MAX_SYMBOLS)) ? jhbd_pkg::VC_W'(MAX_SYMBOLS)
                                                           : b_vc_q;

  // ---- bit walk ----
  localparam int unsigned IDXW_C = jhbd_pkg::IDX_W;
  logic [DIW-1:0]             d;
  logic [L-1:0]               code_w, diff;
  logic [IDXW_C-1:0]          idx;
  logic                       hit;
  logic [LW-1:0]              depth_nx;

  assign d        = depth_q[DIW-1:0];
  assign code_w   = L'({partial_q, bit_req_i});
  assign diff     = code_w - first_q[d];
  assign hit      = (code_w >= first_q[d]) && (CW'(diff) < CW'(placed_q[d]));
  assign idx      = IDXW_C'(offset_q[d]) + IDXW_C'(diff);
  assign depth_nx = depth_q + LW'(1);

  // ---- symbol memory ----
  logic [jhbd_pkg::SYM_W-1:0] ram_rdata;
  logic                       ram_we;

  assign ram_we = cmd_i.load_sym && ({1'b0, position_i} < (jhbd_pkg::POS_W + 1)'(MAX_SYMBOLS));

  jhbd_ram #(
    .WIDTH (jhbd_pkg::SYM_W),
    .DEPTH (MAX_SYMBOLS)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (position_i[AW-1:0]),
    .wdata_i (data_i),
    .re_i    (cmd_i.dec_step && hit),
    .raddr_i (idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // ---- status to controller ----
  assign stat_o.len_zero    = (length_count_i == '0);
  assign stat_o.table_empty = (lengths_q == '0);
  assign stat_o.stuck       = stuck_q;
  assign stat_o.hit         = hit;
  assign stat_o.build_last  = ((LW'(b_idx_q) + LW'(1)) == b_len_q);
  assign stat_o.too_many    = CMPW'(b_total_q) > CMPW'(vc_cap);
  assign stat_o.too_few     = CMPW'(b_total_q) < CMPW'(b_vc_q);

  // ---- tables and build registers (payload) ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_len && ({1'b0, position_i} < (jhbd_pkg::POS_W + 1)'(L))) begin
      cnt_q[position_i[DIW-1:0]] <= data_i;
    end
    if (cmd_i.build_start) begin
      b_idx_q   <= '0;
      b_len_q   <= len_sat;
      b_code_q  <= '0;
      b_free_q  <= CODEW'(1);
      b_total_q <= '0;
      b_vc_q    <= value_count_i;
    end
    if (cmd_i.build_step) begin
      first_q[b_idx_q]  <= code_sh[L-1:0];
      placed_q[b_idx_q] <= put;
      offset_q[b_idx_q] <= jhbd_pkg::OFFSET_W'(b_total_q);
      b_code_q          <= code_sh + CODEW'(put);
      b_free_q          <= free_sh - CODEW'(put);
      b_total_q         <= b_total_q + TOTW'(put);
      b_idx_q           <= b_idx_q + DIW'(1);
    end
    if (cmd_i.dec_step && hit) begin
      sym_ok_q <= (idx < IDXW_C'(MAX_SYMBOLS));
    end
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_symbol_q <= (cmd_i.out_from_ram && sym_ok_q) ? ram_rdata : '0;
    end
  end

  // ---- walk control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lengths_q <= '0;
      partial_q <= '0;
      depth_q   <= '0;
      stuck_q   <= 1'b0;
    end else begin
      if (cmd_i.build_clear) begin
        lengths_q <= '0;
        partial_q <= '0;
        depth_q   <= '0;
        stuck_q   <= 1'b0;
      end
      if (cmd_i.build_finish && !stat_o.too_many && !stat_o.too_few) begin
        lengths_q <= b_len_q;
      end
      if (cmd_i.dec_step) begin
        if (hit) begin
          // symbol found: restart the walk
          partial_q <= '0;
          depth_q   <= '0;
        end else begin
          partial_q <= code_w;
          depth_q   <= depth_nx;
          if (depth_nx >= lengths_q) begin
            stuck_q <= 1'b1;
          end
        end
      end
    end
  end

  assign status_o = out_status_q;
  assign symbol_o = out_symbol_q;

endmodule

// ----- design/jpeg_huffman_bit_decoder.sv -----
// ----------------------------------------------------------------------------
// jpeg_huffman_bit_decoder
// Canonical Huffman decoder with JPEG-style BITS / HUFFVAL tables.
// ----------------------------------------------------------------------------
// Every request yields one result. Count and symbol loads, empty builds and
// decode bits that end pending, on an empty table or on an invalid code are
// loaded into the result register as they are taken; a decode bit that
// completes a symbol first goes through the registered read of the symbol
// memory. In a build, the code assigner handles one length per cycle over
// the code lengths in use, then the symbol count is checked. Results sit in
// an output register, so a new request is taken while the previous result is being drained.
module jpeg_huffman_bit_decoder #(
  parameter int unsigned MAX_CODE_LENGTH = 16,
  parameter int unsigned MAX_SYMBOLS     = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // position[7:0], data[15:8], length_count[20:16], value_count[29:21],
  // bit_req[30], zero fill[31]
  input  logic [jhbd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command[1:0]
  input  logic [jhbd_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // symbol[7:0]
  output logic [jhbd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[2:0]
  output logic [jhbd_pkg::STATUS_W-1:0]  m_axis_tuser
);

  jhbd_pkg::cmd_t  cmd;
  jhbd_pkg::stat_t stat;

  jhbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .command_i (s_axis_tuser),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (cmd),
    .stat_i    (stat)
  );

  jhbd_dpath #(
    .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
    .MAX_SYMBOLS     (MAX_SYMBOLS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .position_i     (s_axis_tdata[7:0]),
    .data_i         (s_axis_tdata[15:8]),
    .length_count_i (s_axis_tdata[20:16]),
    .value_count_i  (s_axis_tdata[29:21]),
    .bit_req_i      (s_axis_tdata[30]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (m_axis_tuser),
    .symbol_o       (m_axis_tdata)
  );

endmodule

// ----- design/jhbd_checker.sv -----
// ----------------------------------------------------------------------------
// jhbd_checker
// Port-level checks of the Huffman bit decoder, bound to the top level.
// ----------------------------------------------------------------------------
module jhbd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [jhbd_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input logic [jhbd_pkg::CMD_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [jhbd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [jhbd_pkg::STATUS_W-1:0]  m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a load answers pending in the next cycle
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (s_axis_tuser == jhbd_pkg::CMD_LOAD_LEN ||
              s_axis_tuser == jhbd_pkg::CMD_LOAD_SYM) |=>
      m_axis_tvalid && m_axis_tuser == jhbd_pkg::ST_PENDING)
    else $error("load request did not answer pending");

  // an empty build answers ok in the next cycle
  a_empty_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser == jhbd_pkg::CMD_BUILD && s_axis_tdata[20:16] == 5'd0 |=>
      m_axis_tvalid && m_axis_tuser == jhbd_pkg::ST_BUILD_OK)
    else $error("empty build did not answer ok");

  // symbol byte is zero unless a symbol is reported
  a_symbol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != jhbd_pkg::ST_SYMBOL |-> m_axis_tdata == '0)
    else $error("symbol byte set without a decoded symbol");

endmodule

bind jpeg_huffman_bit_decoder jhbd_checker u_jhbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/jpeg_huffman_bit_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// jpeg_huffman_bit_decoder_tb
// Stream-level regression of the canonical Huffman bit decoder. An initial
// block queues table loads, builds and coded bit streams that follow the
// canonical codes. A clocked driver offers the requests with random gaps, and
// a clocked monitor drains the results with random stalls. Every result is
// checked against a canonical code table kept alongside the block.
// ----------------------------------------------------------------------------
module jpeg_huffman_bit_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jhbd_pkg::*;

  localparam int unsigned NUM_REQS   = 1950;
  localparam int unsigned STALL_MAX  = 4000;
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned IDLE_PCT   = 33;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  pos;
    logic [7:0]  data;
    logic [4:0]  lc;
    logic [8:0]  vc;
    logic        code_bit;
  } huff_req_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] symbol;
  } huff_result_t;

  // canonical code layout per length, lengths in use after saturation
  typedef struct packed {
    logic [15:0][15:0] first;
    logic [15:0][8:0]  placed;
    logic [15:0][8:0]  offset;
    logic [12:0]       total;
    logic [4:0]        lengths;
  } code_map_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  jpeg_huffman_bit_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  huff_req_t    req_q[$];
  huff_result_t result_q[$];
  huff_req_t    cur_req;

  int unsigned n_req      = 0;
  int unsigned n_results  = 0;
  int unsigned n_symbols  = 0;
  int unsigned n_build_ok = 0;
  int unsigned n_rejects  = 0;
  int unsigned n_invalid  = 0;
  int unsigned n_empty    = 0;
  int unsigned n_errors   = 0;
  int unsigned stall_cnt  = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;

  // decoder state as seen from outside
  logic [15:0][7:0] dec_counts  = '0;
  logic [7:0]       dec_symbols [256];
  code_map_t        dec_map     = '0;
  logic [4:0]       dec_lengths = '0;
  logic [15:0]      dec_partial = '0;
  logic [4:0]       dec_depth   = '0;
  logic             dec_stuck   = 1'b0;

  // generator shadow: what the queued requests will have written
  logic [15:0][7:0] gen_counts  = '0;
  logic [15:0]      gen_cnt_ok  = '0;
  logic [255:0]     gen_sym_ok  = '0;
  code_map_t        gen_map     = '0;
  logic [4:0]       gen_lengths = '0;

  // calm window: no gaps on either side
  wire calm = (n_req >= 700) && (n_req < 1000);

  function automatic code_map_t assign_codes(logic [15:0][7:0] cnt, logic [4:0] lc);
    code_map_t m;
    int code;
    int room;
    int sum;
    int put;
    m = '0;
    code = 0;
    room = 1;
    sum = 0;
    m.lengths = (lc > 5'd16) ? 5'd16 : lc;
    for (int d = 0; d < 16; d++) begin
      if (d < int'(m.lengths)) begin
        code = code << 1;
        room = room << 1;
        put = (int'(cnt[d]) < room) ? int'(cnt[d]) : room;
        m.first[d]  = 16'(code);
        m.placed[d] = 9'(put);
        m.offset[d] = 9'(sum);
        sum  += put;
        code += put;
        room -= put;
      end
    end
    m.total = 13'(sum);
    return m;
  endfunction

  function automatic status_e build_verdict(code_map_t m, logic [8:0] vc);
    int cap;
    cap = (vc > 9'd256) ? 256 : int'(vc);
    if (m.lengths == 0) return ST_BUILD_OK;
    if (int'(m.total) > cap) return ST_TOO_FEW;
    if (int'(m.total) < int'(vc)) return ST_LEFT_OVER;
    return ST_BUILD_OK;
  endfunction

  function automatic huff_result_t decode_result(huff_req_t r);
    huff_result_t res;
    int code;
    int d;
    int idx;
    res = '{status: ST_PENDING, symbol: 8'h00};
    case (r.cmd)
      CMD_LOAD_LEN: begin
        if (r.pos < 8'd16) dec_counts[r.pos[3:0]] = r.data;
      end
      CMD_LOAD_SYM: begin
        dec_symbols[r.pos] = r.data;
      end
      CMD_BUILD: begin
        dec_map = assign_codes(dec_counts, r.lc);
        res.status = build_verdict(dec_map, r.vc);
        dec_lengths = (res.status == ST_BUILD_OK) ? dec_map.lengths : 5'd0;
        dec_partial = '0;
        dec_depth = '0;
        dec_stuck = 1'b0;
      end
      default: begin
        if (dec_lengths == 0) begin
          res.status = ST_EMPTY;
        end else if (dec_stuck) begin
          res.status = ST_INVALID;
        end else begin
          code = int'({dec_partial[14:0], r.code_bit});
          dec_depth = dec_depth + 5'd1;
          d = int'(dec_depth) - 1;
          if (code >= int'(dec_map.first[d]) &&
              code - int'(dec_map.first[d]) < int'(dec_map.placed[d])) begin
            idx = int'(dec_map.offset[d]) + code - int'(dec_map.first[d]);
            res.status = ST_SYMBOL;
            res.symbol = (idx < 256) ? dec_symbols[idx] : 8'h00;
            dec_partial = '0;
            dec_depth = '0;
          end else begin
            dec_partial = 16'(code);
            if (dec_depth >= dec_lengths) dec_stuck = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  // negative argument: draw the field at random
  task automatic push_req(cmd_e c, int pos, int dat, int lc, int vc, int b);
    huff_req_t r;
    r.cmd      = c;
    r.pos      = (pos < 0) ? 8'($urandom_range(255)) : 8'(pos);
    r.data     = (dat < 0) ? 8'($urandom_range(255)) : 8'(dat);
    r.lc       = (lc < 0) ? 5'($urandom_range(31)) : 5'(lc);
    r.vc       = (vc < 0) ? 9'($urandom_range(511)) : 9'(vc);
    r.code_bit = (b < 0) ? 1'($urandom_range(1)) : 1'(b);
    req_q.push_back(r);
  endtask

  task automatic push_count(int d, int v);
    push_req(CMD_LOAD_LEN, d, v, -1, -1, -1);
    if (d < 16) begin
      gen_counts[d] = 8'(v);
      gen_cnt_ok[d] = 1'b1;
    end
  endtask

  task automatic push_symbol(int p, int v);
    push_req(CMD_LOAD_SYM, p, v, -1, -1, -1);
    gen_sym_ok[p] = 1'b1;
  endtask

  // fill any symbol slot the new table can reach before the build itself
  task automatic push_build(int lc, int vc);
    code_map_t m;
    status_e   st;
    m = assign_codes(gen_counts, 5'(lc));
    st = build_verdict(m, 9'(vc));
    if (st == ST_BUILD_OK) begin
      for (int i = 0; i < int'(m.total); i++) begin
        if (!gen_sym_ok[i]) push_symbol(i, $urandom_range(255));
      end
    end
    push_req(CMD_BUILD, -1, -1, lc, vc, -1);
    gen_map = m;
    gen_lengths = (st == ST_BUILD_OK) ? m.lengths : 5'd0;
  endtask

  task automatic push_noise(int n);
    repeat (n) push_req(CMD_DECODE, -1, -1, -1, -1, -1);
  endtask

  // emit whole codewords, MSB first, from the current table
  task automatic push_codewords(int n);
    int used[$];
    int d;
    int code;
    for (int i = 0; i < int'(gen_lengths); i++) begin
      if (gen_map.placed[i] != 0) used.push_back(i);
    end
    if (used.size() == 0) begin
      push_noise(2);
      return;
    end
    repeat (n) begin
      d = used[$urandom_range(used.size() - 1)];
      code = int'(gen_map.first[d]) + int'($urandom_range(int'(gen_map.placed[d]) - 1));
      for (int b = d; b >= 0; b--) push_req(CMD_DECODE, -1, -1, -1, -1, (code >> b) & 1);
    end
  endtask

  task automatic push_table_run();
    code_map_t m;
    int top_len;
    int lc;
    int vc;
    int total;
    top_len = ($urandom_range(3) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
    for (int d = 0; d < 16; d++) begin
      if (d < top_len) begin
        push_count(d, ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(3));
      end else if (!gen_cnt_ok[d] || $urandom_range(7) == 0) begin
        push_count(d, $urandom_range(255));
      end
    end
    if ($urandom_range(9) == 0) push_count($urandom_range(255, 16), $urandom_range(255));
    repeat ($urandom_range(3)) push_symbol($urandom_range(255), $urandom_range(255));
    lc = top_len;
    m = assign_codes(gen_counts, 5'(lc));
    total = int'(m.total);
    case ($urandom_range(9))
      0: vc = $urandom_range(511);
      1: vc = (total < 511) ? total + 1 : 511;
      2: vc = (total > 0) ? total - 1 : 0;
      3: begin
        lc = $urandom_range(31);
        vc = (total > 256) ? $urandom_range(256) : total;
      end
      default: vc = (total > 256) ? $urandom_range(256) : total;
    endcase
    push_build(lc, vc);
    if (gen_lengths != 0) push_codewords($urandom_range(30, 4));
    else push_noise($urandom_range(3, 1));
    if ($urandom_range(3) == 0) push_noise($urandom_range(24, 1));
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        result_q.push_back(decode_result(cur_req));
        n_req++;
      end
      if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        cur_req = req_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_req.cmd;
        s_axis_tdata  <= {1'b0, cur_req.code_bit, cur_req.vc, cur_req.lc,
                          cur_req.data, cur_req.pos};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    huff_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (result_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, got status %0d symbol 0x%02h",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        want = result_q.pop_front();
        if (m_axis_tuser !== want.status) begin
          n_errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, m_axis_tuser);
        end
        if (m_axis_tdata !== want.symbol) begin
          n_errors++;
          $display("%0t: symbol mismatch, expected 0x%02h, got 0x%02h",
                   $time, want.symbol, m_axis_tdata);
        end
        case (want.status)
          ST_SYMBOL:                 n_symbols++;
          ST_BUILD_OK:               n_build_ok++;
          ST_TOO_FEW, ST_LEFT_OVER:  n_rejects++;
          ST_INVALID:                n_invalid++;
          ST_EMPTY:                  n_empty++;
          default: ;
        endcase
      end
    end
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_req >= 1300) begin
      // hold off long enough for the block to back up into its input
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: cycles with work left and no transfer on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (rst_ni && (s_axis_tvalid || req_q.size() != 0 || result_q.size() != 0)) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_MAX) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, stall_cnt, result_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    // empty table, empty build, ignored count loads
    push_req(CMD_DECODE, -1, -1, -1, -1, 0);
    push_req(CMD_DECODE, -1, -1, -1, -1, 1);
    push_build(0, 0);
    push_count(16, 255);
    push_count(255, 0);
    // one code of length 1 and one of length 2, table left incomplete
    for (int d = 0; d < 16; d++) push_count(d, (d < 2) ? 1 : 0);
    push_symbol(0, 8'hFF);
    push_symbol(1, 8'h00);
    push_symbol(255, 8'hA5);
    push_build(31, 2);
    push_req(CMD_DECODE, -1, -1, -1, -1, 0);
    push_req(CMD_DECODE, -1, -1, -1, -1, 1);
    push_req(CMD_DECODE, -1, -1, -1, -1, 0);
    // dead end at the last length, then invalid until rebuilt
    push_build(3, 2);
    push_noise(0);
    push_req(CMD_DECODE, -1, -1, -1, -1, 1);
    push_req(CMD_DECODE, -1, -1, -1, -1, 1);
    push_req(CMD_DECODE, -1, -1, -1, -1, 1);
    push_req(CMD_DECODE, -1, -1, -1, -1, 0);
    // count check: too many codes, codes short of the count, count above cap
    push_build(3, 1);
    push_req(CMD_DECODE, -1, -1, -1, -1, 0);
    push_build(3, 3);
    push_build(3, 511);
    push_build(2, 256);
    push_build(2, 2);
    push_req(CMD_DECODE, -1, -1, -1, -1, 1);
    push_req(CMD_DECODE, -1, -1, -1, -1, 0);
    // full symbol store: 255 codes of length 8 and one of length 9
    for (int d = 0; d < 16; d++) push_count(d, (d == 7) ? 255 : ((d == 8) ? 1 : 0));
    push_build(9, 256);
    push_codewords(20);
    while (req_q.size() < NUM_REQS) push_table_run();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d requests and %0d results: %0d symbols decoded, %0d builds ok, %0d rejected",
             n_req, n_results, n_symbols, n_build_ok, n_rejects);
    $display("  %0d invalid-code and %0d empty-table answers, %0d check failures",
             n_invalid, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
